/* sv/ddd_pkg.sv */
package ddd_pkg;

  localparam int YEAR_W   = 14;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int SERIAL_W = 22;

  // Largest year taken as given; larger years clamp to it.
  localparam int YEAR_MAX = 9999;

  localparam int MONTH_FEB = 2;
  localparam int MONTH_DEC = 12;

  // Divide by 100 through a reciprocal: floor(x * 5243 / 2^19) is exact for x < 2^14.
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int QUOT_W       = 7;

  localparam int DAYS_YEAR = 365;
  localparam int CENTURY   = 100;

  function automatic logic [QUOT_W-1:0] div100(input logic [YEAR_W-1:0] x);
    logic [27:0] prod;
    prod = 28'(x) * 28'(DIV100_MUL);
    return prod[DIV100_SHIFT +: QUOT_W];
  endfunction

  // Days in all months before the given one, common year.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

/* sv/ddd_lane.sv */
module ddd_lane (
  input  logic                            clk,
  input  logic [ddd_pkg::DAY_W-1:0]       day,
  input  logic [ddd_pkg::MONTH_W-1:0]     month,
  input  logic [ddd_pkg::YEAR_W-1:0]      year,
  output logic [ddd_pkg::SERIAL_W-1:0]    serial
);
  import ddd_pkg::*;

  logic [MONTH_W-1:0]  m_c;
  logic [YEAR_W-1:0]   y_c;
  logic [YEAR_W-1:0]   prev;
  logic [22:0]         p365_full;

  // Stage 1 registers
  logic [SERIAL_W-1:0] p365;
  logic [YEAR_W-3:0]   q4;
  logic [QUOT_W-1:0]   q100;
  logic [QUOT_W-1:0]   q400;
  logic [QUOT_W-1:0]   yq100;
  logic [YEAR_W-1:0]   y1;
  logic [MONTH_W-1:0]  m1;
  logic [DAY_W-1:0]    d1;

  logic [YEAR_W-1:0]   c100;
  logic                leap;
  logic [SERIAL_W-1:0] serial_next;

  always_comb begin
    if (month == '0) begin
      m_c = MONTH_W'(1);
    end else if (month > MONTH_W'(MONTH_DEC)) begin
      m_c = MONTH_W'(MONTH_DEC);
    end else begin
      m_c = month;
    end
    if (year == '0) begin
      y_c = YEAR_W'(1);
    end else if (year > YEAR_W'(YEAR_MAX)) begin
      y_c = YEAR_W'(YEAR_MAX);
    end else begin
      y_c = year;
    end
    prev      = y_c - YEAR_W'(1);
    p365_full = 23'(prev) * 23'(DAYS_YEAR);
  end

  always_ff @(posedge clk) begin
    p365  <= p365_full[SERIAL_W-1:0];
    q4    <= prev[YEAR_W-1:2];
    q100  <= div100(prev);
    q400  <= div100({2'b00, prev[YEAR_W-1:2]});
    yq100 <= div100(y_c);
    y1    <= y_c;
    m1    <= m_c;
    d1    <= day;
  end

  // Leap: divisible by 4, and not a century unless the century count is a multiple of 4.
  always_comb begin
    c100 = YEAR_W'(yq100) * YEAR_W'(CENTURY);
    leap = (y1[1:0] == 2'b00) && ((y1 != c100) || (yq100[1:0] == 2'b00));
    serial_next = p365 + SERIAL_W'(q4) - SERIAL_W'(q100) + SERIAL_W'(q400)
                + SERIAL_W'(days_before_month(m1))
                + SERIAL_W'(leap && (m1 > MONTH_W'(MONTH_FEB)))
                + SERIAL_W'(d1);
  end

  always_ff @(posedge clk) begin
    serial <= serial_next;
  end

endmodule

/* sv/ddd_merge.sv */
module ddd_merge (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  input  logic [ddd_pkg::SERIAL_W-1:0] serial_a,
  input  logic [ddd_pkg::SERIAL_W-1:0] serial_b,
  output logic                         done,
  output logic [ddd_pkg::SERIAL_W-1:0] day_distance
);
  import ddd_pkg::*;

  logic [SERIAL_W-1:0] distance_next;

  always_comb begin
    if (serial_a >= serial_b) begin
      distance_next = serial_a - serial_b;
    end else begin
      distance_next = serial_b - serial_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  always_ff @(posedge clk) begin
    day_distance <= distance_next;
  end

endmodule

/* sv/date_day_distance.sv */
// Channel   Handshake        Beat payload
// --------  ---------------  -------------------------------------------------
// command   start / busy     first_day, first_month, first_year,
//                            second_day, second_month, second_year
// result    done (strobe)    day_distance
//
// One beat is taken every cycle; busy is held low, nothing inside ever stalls.
// An accepted beat passes lane stage 1, lane stage 2 and the merge register; its result
// shows with done once the merge register holds it. Two lanes turn the dates into
// serial day numbers (stage 1: clamp and constant-divisor reciprocals,
// stage 2: leap test and sum); the merge stage registers the absolute difference.
// Synchronous reset clears only the valid pipe; results cannot be held off.
module date_day_distance (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ddd_pkg::DAY_W-1:0]    first_day,
  input  logic [ddd_pkg::MONTH_W-1:0]  first_month,
  input  logic [ddd_pkg::YEAR_W-1:0]   first_year,
  input  logic [ddd_pkg::DAY_W-1:0]    second_day,
  input  logic [ddd_pkg::MONTH_W-1:0]  second_month,
  input  logic [ddd_pkg::YEAR_W-1:0]   second_year,
  output logic                         done,
  output logic [ddd_pkg::SERIAL_W-1:0] day_distance
);
  import ddd_pkg::*;

  logic                accept;
  logic                v1;
  logic                v2;
  logic [SERIAL_W-1:0] serial_a;
  logic [SERIAL_W-1:0] serial_b;

  // Fully pipelined: never refuse a beat.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Track which pipeline slots carry a live beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  ddd_lane u_lane_a (
    .clk    (clk),
    .day    (first_day),
    .month  (first_month),
    .year   (first_year),
    .serial (serial_a)
  );

  ddd_lane u_lane_b (
    .clk    (clk),
    .day    (second_day),
    .month  (second_month),
    .year   (second_year),
    .serial (serial_b)
  );

  // Combine both serial numbers into the distance beat.
  ddd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .valid        (v2),
    .serial_a     (serial_a),
    .serial_b     (serial_b),
    .done         (done),
    .day_distance (day_distance)
  );

endmodule

/* verif/day_distance_board_pkg.sv */
package day_distance_board_pkg;
  import ddd_pkg::*;

  // Scoreboard for the date distance block: predict each distance when a command beat is
  // taken, match it against the result beats in order.
  class day_distance_board;
    int unsigned         month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    logic [SERIAL_W-1:0] owed_distances[$];
    int                  errors;

    function new();
      errors = 0;
    endfunction

    function bit leap_year(int unsigned yr);
      return ((yr % 4 == 0) && (yr % CENTURY != 0)) || (yr % 400 == 0);
    endfunction

    // Days from the start of the calendar up to and including the given date.
    function int unsigned serial_of(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                    logic [YEAR_W-1:0] y);
      int unsigned mon;
      int unsigned yr;
      int unsigned prev;
      int unsigned total;
      mon = m;
      yr  = y;
      if (mon < 1) mon = 1;
      if (mon > MONTH_DEC) mon = MONTH_DEC;
      if (yr < 1) yr = 1;
      if (yr > YEAR_MAX) yr = YEAR_MAX;
      prev  = yr - 1;
      total = prev * DAYS_YEAR + prev / 4 - prev / CENTURY + prev / 400;
      for (int i = 1; i < mon; i++) begin
        total += month_len[i-1];
        if (i == MONTH_FEB && leap_year(yr)) total += 1;
      end
      return total + d;
    endfunction

    function void note(logic [DAY_W-1:0] d1, logic [MONTH_W-1:0] m1, logic [YEAR_W-1:0] y1,
                       logic [DAY_W-1:0] d2, logic [MONTH_W-1:0] m2, logic [YEAR_W-1:0] y2);
      int unsigned a;
      int unsigned b;
      int unsigned diff;
      a    = serial_of(d1, m1, y1);
      b    = serial_of(d2, m2, y2);
      diff = (a >= b) ? a - b : b - a;
      owed_distances.push_back(SERIAL_W'(diff));
    endfunction

    function void check(logic [SERIAL_W-1:0] got);
      logic [SERIAL_W-1:0] want;
      if (owed_distances.size() == 0) begin
        $error("day_distance: no result expected, got %0d", got);
        errors++;
      end else begin
        want = owed_distances.pop_front();
        if (got !== want) begin
          $error("day_distance: expected %0d, got %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return owed_distances.size();
    endfunction
  endclass

endpackage

/* verif/date_day_distance_tb.sv */
module date_day_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ddd_pkg::*;
  import day_distance_board_pkg::*;

  logic                clk;
  logic                rst          = 1'b1;
  logic                start        = 1'b0;
  logic                busy;
  logic [DAY_W-1:0]    first_day    = '0;
  logic [MONTH_W-1:0]  first_month  = '0;
  logic [YEAR_W-1:0]   first_year   = '0;
  logic [DAY_W-1:0]    second_day   = '0;
  logic [MONTH_W-1:0]  second_month = '0;
  logic [YEAR_W-1:0]   second_year  = '0;
  logic                done;
  logic [SERIAL_W-1:0] day_distance;

  // Chance, in percent, that the sender sits idle for another cycle before a beat.
  int idle_pct = 0;

  day_distance_board board = new();

  date_day_distance uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .first_day    (first_day),
    .first_month  (first_month),
    .first_year   (first_year),
    .second_day   (second_day),
    .second_month (second_month),
    .second_year  (second_year),
    .done         (done),
    .day_distance (day_distance)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: this limit lies far beyond the length of a healthy run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Monitor both channels at the clock edge. All drives are nonblocking, so the values
  // seen here are the ones the block itself samples at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        board.note(first_day, first_month, first_year, second_day, second_month, second_year);
      if (done)
        board.check(day_distance);
    end
  end

  // Present one command beat and hold it until the block takes it. Insert a random idle
  // stretch first; start is written once per time step, either dropped for the gap or
  // raised for the beat.
  task automatic send_dates(input logic [DAY_W-1:0] d1, input logic [MONTH_W-1:0] m1,
                            input logic [YEAR_W-1:0] y1, input logic [DAY_W-1:0] d2,
                            input logic [MONTH_W-1:0] m2, input logic [YEAR_W-1:0] y2);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    first_day    <= d1;
    first_month  <= m1;
    first_year   <= y1;
    second_day   <= d2;
    second_month <= m2;
    second_year  <= y2;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold off until every predicted distance has come back. Always let at
  // least one edge pass so start is never lowered and raised in the same step.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Pick one date. Most are proper calendar dates; a quarter sit around February of a
  // century year to hit the leap rule; a tenth are raw noise over the full field widths
  // (day zero, months 0 and 13..15, year zero and years past the clamp).
  task automatic pick_date(output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] m,
                           output logic [YEAR_W-1:0] y);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      d = DAY_W'($urandom_range(0, 31));
      m = MONTH_W'($urandom_range(0, 15));
      y = YEAR_W'($urandom_range(0, 16383));
    end else if (roll < 35) begin
      y = YEAR_W'(100 * $urandom_range(1, 99) + $urandom_range(0, 4));
      m = MONTH_W'($urandom_range(1, 3));
      d = DAY_W'($urandom_range(1, 29));
    end else begin
      y = YEAR_W'($urandom_range(1, YEAR_MAX));
      m = MONTH_W'($urandom_range(1, 12));
      // Run past the month end now and then; the block adds the day as given.
      d = ($urandom_range(3) == 0) ? DAY_W'($urandom_range(29, 31))
                                   : DAY_W'($urandom_range(1, 28));
    end
  endtask

  // Random pairs at a given idle rate. A third of the pairs share the first year, so
  // short distances and same-month differences show up often.
  task automatic run_phase(input int pct, input int count);
    logic [DAY_W-1:0]   d1, d2;
    logic [MONTH_W-1:0] m1, m2;
    logic [YEAR_W-1:0]  y1, y2;
    idle_pct = pct;
    repeat (count) begin
      pick_date(d1, m1, y1);
      pick_date(d2, m2, y2);
      if ($urandom_range(2) == 0) y2 = y1;
      send_dates(d1, m1, y1, d2, m2, y2);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats, back to back.
    idle_pct = 0;
    send_dates(5'd1, 4'd1, 14'd1, 5'd1, 4'd1, 14'd1);            // equal dates
    send_dates(5'd31, 4'd12, 14'd9999, 5'd1, 4'd1, 14'd1);       // widest span
    send_dates(5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999);       // same, swapped
    send_dates(5'd28, 4'd2, 14'd2000, 5'd1, 4'd3, 14'd2000);     // leap by the 400 rule
    send_dates(5'd28, 4'd2, 14'd1900, 5'd1, 4'd3, 14'd1900);     // century, not leap
    send_dates(5'd29, 4'd2, 14'd2004, 5'd1, 4'd3, 14'd2003);     // ordinary leap year
    send_dates(5'd0, 4'd1, 14'd2024, 5'd31, 4'd13, 14'd2023);    // day zero, month 13
    send_dates(5'd15, 4'd0, 14'd0, 5'd15, 4'd15, 14'd16383);     // month/year clamps
    send_dates(5'd31, 4'd4, 14'd10000, 5'd1, 4'd5, 14'd9999);    // day past month end
    send_dates(5'd31, 4'd6, 14'd1600, 5'd1, 4'd7, 14'd1700);
    // Walk every month against the start of the previous year.
    for (int mon = 1; mon <= MONTH_DEC; mon++)
      send_dates(5'd31, MONTH_W'(mon), 14'd2000, 5'd1, 4'd1, 14'd1999);
    drain();

    // Random beats: no idling, sender idle 45%, no idling again, then light idling.
    run_phase(0, 190);
    run_phase(45, 190);
    drain();
    run_phase(0, 180);
    run_phase(17, 190);

    // Wait out the pipe, then keep watching for anything stray before the verdict.
    drain();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* date_day_distance.f */
sv/ddd_pkg.sv
sv/ddd_lane.sv
sv/ddd_merge.sv
sv/date_day_distance.sv
verif/day_distance_board_pkg.sv
verif/date_day_distance_tb.sv
